// ----- hdl/psw_pkg.sv -----
`timescale 1ns / 1ps
// psw_pkg: shared types and constants for the packed symbol word unpacker
// no dependencies

package psw_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_WORD_BITS     = 2'd0;
  localparam logic [1:0] CFG_WIDE_ALPHABET = 2'd1;
  localparam logic [1:0] CFG_FIXED_LENGTH  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int WB_W       = 7;  // word_bits register width
  localparam int PER_W      = 5;  // symbols per word, at most 21
  localparam int SYM_W      = 5;

  localparam logic [WB_W-1:0]  WORD_BITS_RST = 7'd64;
  localparam logic [SYM_W-1:0] MASK_NARROW   = 5'h07;
  localparam logic [SYM_W-1:0] MASK_WIDE     = 5'h1f;
  localparam logic [2:0]       SYM_NARROW    = 3'd3;
  localparam logic [2:0]       SYM_WIDE      = 3'd5;

  // per-word control that travels through the queue with the word
  typedef struct packed {
    logic             wide;
    logic [7:0]       fixed_len;
    logic [PER_W-1:0] per;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  // one result
  typedef struct packed {
    logic [SYM_W-1:0] value;
    logic             present;
    logic             eos;
    logic             last;
  } res_t;

endpackage

// ----- hdl/packed_symbol_word_unpacker.sv -----
`timescale 1ns / 1ps
// packed_symbol_word_unpacker: top level, front + queue + back
// depends on psw_pkg, psw_front, psw_queue, psw_back

// Unpacks one packed word into 3-bit or 5-bit symbols, most significant
// symbol first. The front latches configuration, masks each word to
// word_bits, works out the number of symbol slots and drops words that are
// narrower than one symbol; a two-entry queue then decouples it from the
// back, which steps through the slots one per cycle unless the output
// stalls. In fixed-length mode the back tracks the symbols left in the
// signature and flags the last one; in variable mode all-ones slots are
// skipped, zero gives a bare terminator and other values come out minus
// one. The back handles a word by load, the walk over its slots and
// close-out. The last result of a word is held back one slot so its
// last_of_word flag can be set once no further result follows.
// Configuration writes are always ready and take effect on the next word.

module packed_symbol_word_unpacker #(
  parameter int MAX_WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [MAX_WORD_BITS-1:0]        in_packed_word,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [psw_pkg::SYM_W-1:0]       out_symbol_value,
  output logic                            out_symbol_present,
  output logic                            out_end_of_signature,
  output logic                            out_last_of_word
);
  import psw_pkg::*;

  localparam int Q_W = CTL_W + MAX_WORD_BITS;

  logic                     q_full;
  logic                     q_empty;
  logic                     q_push;
  logic                     q_pop;
  logic [MAX_WORD_BITS-1:0] f_word;
  ctl_t                     f_ctl;
  logic [Q_W-1:0]           q_rd;
  ctl_t                     b_ctl;
  res_t                     res;

  // front: config, accept, mask, slot count
  psw_front #(
    .MAX_WORD_BITS(MAX_WORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_packed_word (in_packed_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_word         (f_word),
    .q_ctl          (f_ctl)
  );

  // word queue, control bits travel alongside the masked word
  psw_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctl, f_word}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rd)
  );

  assign b_ctl = q_rd[Q_W-1:MAX_WORD_BITS];

  // back: slot walk, signature tracking, output register
  psw_back #(
    .MAX_WORD_BITS(MAX_WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_word    (q_rd[MAX_WORD_BITS-1:0]),
    .q_ctl     (b_ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_symbol_value     = res.value;
  assign out_symbol_present   = res.present;
  assign out_end_of_signature = res.eos;
  assign out_last_of_word     = res.last;

endmodule

// ----- hdl/psw_front.sv -----
`timescale 1ns / 1ps
// psw_front: configuration registers, word accept, masking and slot count
// depends on psw_pkg

module psw_front #(
  parameter int MAX_WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [MAX_WORD_BITS-1:0]        in_packed_word,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [MAX_WORD_BITS-1:0]        q_word,
  output psw_pkg::ctl_t                   q_ctl
);
  import psw_pkg::*;

  logic [WB_W-1:0]          word_bits_r;
  logic                     wide_r;
  logic [7:0]               fixed_len_r;
  logic [WB_W-1:0]          wb_cl;
  logic [2:0]               sym_w;
  logic                     usable;
  logic [12:0]              prod3;
  logic [14:0]              prod5;
  logic [MAX_WORD_BITS-1:0] wmask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_bits_r <= WORD_BITS_RST;
      wide_r      <= 1'b0;
      fixed_len_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WORD_BITS:     word_bits_r <= cfg_data[WB_W-1:0];
        CFG_WIDE_ALPHABET: wide_r      <= cfg_data[0];
        CFG_FIXED_LENGTH:  fixed_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wb_cl = (word_bits_r > WB_W'(MAX_WORD_BITS)) ? WB_W'(MAX_WORD_BITS) : word_bits_r;
    sym_w = wide_r ? SYM_WIDE : SYM_NARROW;
    usable = (wb_cl >= {4'd0, sym_w});
    // divide by 3 or 5 through a reciprocal, exact for widths up to 64
    prod3 = {6'd0, wb_cl} * 13'd43;
    prod5 = {8'd0, wb_cl} * 15'd205;
    for (int b = 0; b < MAX_WORD_BITS; b++) begin
      wmask[b] = (WB_W'(b) < wb_cl);
    end
  end

  assign in_stall         = q_full;
  assign q_push           = in_valid && !q_full && usable;
  assign q_word           = in_packed_word & wmask;
  assign q_ctl.wide       = wide_r;
  assign q_ctl.fixed_len  = fixed_len_r;
  assign q_ctl.per        = wide_r ? prod5[14:10] : prod3[11:7];

endmodule

// ----- hdl/psw_queue.sv -----
`timescale 1ns / 1ps
// psw_queue: two-entry queue between front and back
// no dependencies

module psw_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/psw_back.sv -----
`timescale 1ns / 1ps
// psw_back: walks the symbol slots of a queued word, one slot a cycle unless the output stalls
// depends on psw_pkg

module psw_back #(
  parameter int MAX_WORD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic [MAX_WORD_BITS-1:0]  q_word,
  input  psw_pkg::ctl_t             q_ctl,
  output logic                      out_valid,
  input  logic                      out_stall,
  output psw_pkg::res_t             out_res
);
  import psw_pkg::*;

  localparam int POS_W = $clog2(MAX_WORD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [MAX_WORD_BITS-1:0] word_r, word_nxt;
  logic                     wide_r, wide_nxt;
  logic                     fixed_r, fixed_nxt;
  logic [7:0]               rem_r, rem_nxt;
  logic [PER_W-1:0]         cnt_r, cnt_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  res_t                     hold_r, hold_nxt;
  logic                     hold_v_r, hold_v_nxt;
  res_t                     out_r, out_nxt;
  logic                     out_v_r, out_v_nxt;

  logic [MAX_WORD_BITS-1:0] shifted;
  logic [SYM_W-1:0]         sym;
  logic [SYM_W-1:0]         smask;
  logic [2:0]               sym_w;
  logic                     emits;
  res_t                     cand;
  logic                     out_free;
  logic [7:0]               rem_ld;
  logic [PER_W-1:0]         n_ld;
  logic [PER_W-1:0]         n_m1;
  logic [6:0]               pos_full;

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_comb begin
    out_free = !out_v_r || !out_stall;
    sym_w    = wide_r ? SYM_WIDE : SYM_NARROW;
    smask    = wide_r ? MASK_WIDE : MASK_NARROW;
    shifted  = word_r >> pos_r;
    sym      = wide_r ? shifted[4:0] : {2'b00, shifted[2:0]};
    emits    = fixed_r || (sym != smask);

    // candidate result for the current slot
    cand.last = 1'b0;
    if (fixed_r) begin
      cand.value   = sym;
      cand.present = 1'b1;
      cand.eos     = (rem_r == 8'd1);
    end else if (sym == '0) begin
      cand.value   = '0;
      cand.present = 1'b0;
      cand.eos     = 1'b1;
    end else begin
      cand.value   = sym - 5'd1;
      cand.present = 1'b1;
      cand.eos     = 1'b0;
    end

    // load-time slot count and starting bit position
    rem_ld   = (rem_r == 8'd0) ? q_ctl.fixed_len : rem_r;
    if (q_ctl.fixed_len != 8'd0 && {3'd0, q_ctl.per} > rem_ld) begin
      n_ld = rem_ld[PER_W-1:0];
    end else begin
      n_ld = q_ctl.per;
    end
    n_m1     = n_ld - 5'd1;
    pos_full = {2'b00, n_m1} * {4'd0, (q_ctl.wide ? SYM_WIDE : SYM_NARROW)};

    state_nxt  = state_r;
    word_nxt   = word_r;
    wide_nxt   = wide_r;
    fixed_nxt  = fixed_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && out_stall;
    q_pop      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          word_nxt  = q_word;
          wide_nxt  = q_ctl.wide;
          fixed_nxt = (q_ctl.fixed_len != 8'd0);
          if (q_ctl.fixed_len != 8'd0) rem_nxt = rem_ld;
          cnt_nxt   = n_ld;
          pos_nxt   = pos_full[POS_W-1:0];
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // a new result pushes the held one out, so it needs a free output slot
        if (!(emits && hold_v_r && !out_free)) begin
          if (emits) begin
            if (hold_v_r) begin
              out_nxt   = hold_r;
              out_v_nxt = 1'b1;
            end
            hold_nxt   = cand;
            hold_v_nxt = 1'b1;
            if (fixed_r) rem_nxt = rem_r - 8'd1;
          end
          cnt_nxt = cnt_r - 5'd1;
          pos_nxt = pos_r - POS_W'(sym_w);
          if (cnt_r == 5'd1) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rem_r    <= 8'd0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rem_r    <= rem_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    wide_r  <= wide_nxt;
    fixed_r <= fixed_nxt;
    cnt_r   <= cnt_nxt;
    pos_r   <= pos_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ----- tb/psw_checker.sv -----
`timescale 1ns / 1ps
// psw_checker: watches the config, word and result channels of the unpacker,
// predicts the symbols of each accepted word and compares them in order
// depends on psw_pkg

module psw_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [63:0]                    in_packed_word,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [psw_pkg::SYM_W-1:0]      out_symbol_value,
  input  logic                           out_symbol_present,
  input  logic                           out_end_of_signature,
  input  logic                           out_last_of_word,
  output int                             fail_count,
  output int                             pending
);
  import psw_pkg::*;

  // shadow copy of the registers and the signature counter
  logic [WB_W-1:0] word_bits_q;
  logic            wide_q;
  logic [7:0]      fixed_len_q;
  logic [7:0]      sig_left;

  res_t expected_syms[$];
  res_t oldest;
  int   errors = 0;

  assign fail_count = errors;
  assign pending    = expected_syms.size();

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // expected symbols of one word, appended to the queue
  function automatic void predict_word(input logic [63:0] raw);
    res_t            word_res[$];
    res_t            r;
    logic [63:0]     w;
    logic [SYM_W-1:0] mask;
    logic [SYM_W-1:0] sym;
    int              sw;
    int              wb;
    int              per;
    int              n;
    int              i;
    sw   = wide_q ? 5 : 3;
    mask = wide_q ? MASK_WIDE : MASK_NARROW;
    wb   = (word_bits_q > 64) ? 64 : int'(word_bits_q);
    if (wb < sw) return;  // narrower than one symbol: dropped
    w   = (wb < 64) ? (raw & ((64'd1 << wb) - 64'd1)) : raw;
    per = wb / sw;
    if (fixed_len_q != 0) begin
      if (sig_left == 0) sig_left = fixed_len_q;
      n = (per < int'(sig_left)) ? per : int'(sig_left);
      for (i = 0; i < n; i++) begin
        sym      = SYM_W'(w >> ((n - 1 - i) * sw)) & mask;
        sig_left = sig_left - 8'd1;
        r        = '{value: sym, present: 1'b1, eos: (sig_left == 8'd0), last: 1'b0};
        word_res.push_back(r);
      end
    end else begin
      for (i = 0; i < per; i++) begin
        sym = SYM_W'(w >> ((per - 1 - i) * sw)) & mask;
        if (sym == mask) continue;  // padding slot
        if (sym == '0)
          r = '{value: '0, present: 1'b0, eos: 1'b1, last: 1'b0};
        else
          r = '{value: sym - 1'b1, present: 1'b1, eos: 1'b0, last: 1'b0};
        word_res.push_back(r);
      end
    end
    if (word_res.size() != 0) word_res[word_res.size() - 1].last = 1'b1;
    foreach (word_res[k]) expected_syms.push_back(word_res[k]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      word_bits_q = WORD_BITS_RST;
      wide_q      = 1'b0;
      fixed_len_q = 8'd0;
      sig_left    = 8'd0;
      expected_syms.delete();
    end else begin
      // a word taken on the same edge as a write still sees the old settings
      if (in_valid && !in_stall) predict_word(in_packed_word);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WORD_BITS:     word_bits_q = cfg_data[WB_W-1:0];
          CFG_WIDE_ALPHABET: wide_q = cfg_data[0];
          CFG_FIXED_LENGTH:  fixed_len_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_syms.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual value %0d present %0b",
                   $time, out_symbol_value, out_symbol_present);
        end else begin
          oldest = expected_syms.pop_front();
          compare_field("symbol_value", oldest.value, out_symbol_value);
          compare_field("symbol_present", oldest.present, out_symbol_present);
          compare_field("end_of_signature", oldest.eos, out_end_of_signature);
          compare_field("last_of_word", oldest.last, out_last_of_word);
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: clock, reset, config writes and packed word stimulus for the unpacker
// depends on psw_pkg, psw_checker and packed_symbol_word_unpacker

module testbench;
  import psw_pkg::*;

  // index 3 is not a register, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // a word ties up the back while its slots are walked and two more can sit in
  // front of it, so this covers words that leave no result behind
  localparam int IDLE_CYCLES = 100;
  localparam int RANDOM_WORDS = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_packed_word = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SYM_W-1:0] out_symbol_value;
  logic             out_symbol_present;
  logic             out_end_of_signature;
  logic             out_last_of_word;

  int fail_count;
  int pending;

  // words waiting to be sent in the current phase
  logic [63:0] word_q[$];

  // receiver stall pattern state
  int stall_mode = 0;
  int stall_left = 0;

  always #2 clk = ~clk;

  packed_symbol_word_unpacker i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_packed_word       (in_packed_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_symbol_value     (out_symbol_value),
    .out_symbol_present   (out_symbol_present),
    .out_end_of_signature (out_end_of_signature),
    .out_last_of_word     (out_last_of_word)
  );

  psw_checker i_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_packed_word       (in_packed_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_symbol_value     (out_symbol_value),
    .out_symbol_present   (out_symbol_present),
    .out_end_of_signature (out_end_of_signature),
    .out_last_of_word     (out_last_of_word),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  // receiver: switches between no stall, coin flip, a pattern keyed to the
  // stretch counter and heavy stall, each mode held for a random stretch
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= (stall_left % 3 == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // wait until every predicted symbol is out, then let the block settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [7:0] wbits, input logic [7:0] wide,
                            input logic [7:0] flen);
    wait_idle();
    write_reg(CFG_WORD_BITS, wbits);
    write_reg(CFG_WIDE_ALPHABET, wide);
    write_reg(CFG_FIXED_LENGTH, flen);
    cfg_valid <= 1'b0;
  endtask

  // send the queued words in bursts with random gaps; now and then hold
  // off until every expected symbol has come back
  task automatic flush_words();
    int burst;
    int gap;
    bit hold;
    burst = $urandom_range(1, 12);
    while (word_q.size() != 0) begin
      in_valid       <= 1'b1;
      in_packed_word <= word_q.pop_front();
      do @(posedge clk); while (in_stall);
      burst--;
      if (burst == 0 && word_q.size() != 0) begin
        // long bursts give stretches with no sender idling
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 40);
        hold = ($urandom_range(0, 24) == 0);
        if (hold || gap != 0) begin
          in_valid <= 1'b0;
          if (hold) begin
            @(posedge clk);
            while (pending != 0) @(posedge clk);
          end
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // symbol slots get padding or a terminator one time in ten each, else a value;
  // top padding bits left random; a quarter of the words are plain noise
  function automatic logic [63:0] make_word(input int wbits, input bit wide);
    logic [63:0] w;
    logic [63:0] sym;
    int          sw;
    int          per;
    int          i;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return w;
    sw  = wide ? 5 : 3;
    per = ((wbits > 64) ? 64 : wbits) / sw;
    for (i = 0; i < per; i++) begin
      case ($urandom_range(0, 9))
        0: sym = wide ? 64'h1f : 64'h07;
        1: sym = 64'd0;
        default: sym = $urandom_range(1, wide ? 30 : 6);
      endcase
      w = (w & ~((wide ? 64'h1f : 64'h07) << (i * sw))) | (sym << (i * sw));
    end
    return w;
  endfunction

  initial begin
    int  sent;
    int  n;
    int  wbits;
    int  flen;
    bit  wide;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 64-bit words, 3-bit symbols, terminated signatures
    word_q.push_back(64'h0);                    // all terminators
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);  // escape-like word, only padding
    word_q.push_back(64'h8000_0000_0000_0000);  // set bit lies in top padding
    word_q.push_back(64'h0123_4567_89AB_CDEF);
    word_q.push_back(64'h7FFF_FFFF_FFFF_FFFE);
    flush_words();

    // one 5-bit slot, upper bits must be masked off
    set_config(8'd5, 8'd1, 8'd0);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFE0);
    word_q.push_back(64'h1F);
    word_q.push_back(64'h1E);
    word_q.push_back(64'h01);
    flush_words();

    // words narrower than one symbol are dropped
    set_config(8'd4, 8'd1, 8'd0);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    flush_words();
    set_config(8'd2, 8'd0, 8'd0);
    word_q.push_back(64'h5);
    flush_words();
    set_config(8'd0, 8'hFE, 8'd0);
    @(posedge clk);
    write_reg(CFG_UNUSED, 8'hA5);
    cfg_valid <= 1'b0;
    word_q.push_back(64'h7);
    flush_words();

    // fixed length 4, two slots per 7-bit word: signature left half done
    set_config(8'd7, 8'd0, 8'd4);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FF3A);
    flush_words();
    // variable mode in between must leave the open signature alone
    set_config(8'd64, 8'd0, 8'd0);
    word_q.push_back(64'h0);
    flush_words();
    // back to fixed with another length: the open signature finishes first
    set_config(8'd64, 8'd1, 8'd9);
    word_q.push_back(64'h0123_4567_89AB_CDEF);
    word_q.push_back(64'hFEDC_BA98_7654_3210);
    flush_words();
    // oversized word_bits clamps to 64, longest signature
    set_config(8'hFF, 8'd0, 8'd255);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    word_q.push_back(64'h0);
    flush_words();

    // random phases, each under its own settings
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wide = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
        0: wbits = 64;
        1: wbits = $urandom_range(65, 127);
        2: wbits = wide ? 5 : 3;
        default: wbits = $urandom_range(wide ? 5 : 3, 64);
      endcase
      case ($urandom_range(0, 5))
        0, 1: flen = 0;
        2: flen = 255;
        3: flen = 1;
        default: flen = $urandom_range(2, 12);
      endcase
      set_config({1'($urandom_range(0, 1)), 7'(wbits)},
                 {7'($urandom_range(0, 127)), wide}, 8'(flen));
      n = $urandom_range(20, 45);
      if (n > RANDOM_WORDS - sent) n = RANDOM_WORDS - sent;
      repeat (n) word_q.push_back(make_word(wbits, wide));
      flush_words();
      sent += n;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("** packed_symbol_word_unpacker: PASSED **");
    end else begin
      $display("** packed_symbol_word_unpacker: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("** packed_symbol_word_unpacker: FAILED **");
    $finish;
  end

endmodule

// ----- packed_symbol_word_unpacker.f -----
hdl/psw_pkg.sv
hdl/psw_front.sv
hdl/psw_queue.sv
hdl/psw_back.sv
hdl/packed_symbol_word_unpacker.sv
tb/psw_checker.sv
tb/testbench.sv
